[sv/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is low
`define PVE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[sv/pve_pkg.sv]
package pve_pkg;

  localparam int SampleW   = 12;
  localparam int LevelW    = 7;
  localparam int DeadbandW = 12;
  localparam int ShiftW    = 4;
  localparam int CfgDataW  = 12;
  localparam int CfgIdxW   = 1;

  localparam int SampleMax = 4095;
  localparam int LevelMax  = 127;

  localparam logic [DeadbandW-1:0] DeadbandReset = DeadbandW'(16);
  localparam logic [ShiftW-1:0]    ShiftReset    = ShiftW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    RegDeadband = 1'b0,
    RegShift    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
  } sample_t;

  typedef struct packed {
    logic [LevelW-1:0]  volume_level;
    logic               volume_changed;
    logic [SampleW-1:0] smoothed_level;
  } result_t;

  // centre of each level on the sample scale
  typedef logic [SampleW-1:0] centre_table_t [LevelMax+1];

  function automatic centre_table_t build_centre();
    centre_table_t t;
    for (int i = 0; i <= LevelMax; i++) begin
      t[i] = SampleW'((i * SampleMax) / LevelMax);
    end
    return t;
  endfunction

  localparam centre_table_t CentreTable = build_centre();

endpackage

[sv/pve_stream_if.sv]
interface pve_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/pot_volume_ema_hysteresis.sv]
// Potentiometer volume follower.
// in_i carries one 12-bit converter sample per transfer; out_o returns one
// result per sample: the 7-bit volume level, a change flag and the 12-bit
// moving average. Order is kept and every sample gives exactly one result.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 deadband, 1 smoothing shift) at the clock edge; write only while idle.
// A sample is registered at its input transfer; the average and level are
// computed from that register and land in the result register, which
// drives out_o.valid. Throughput: one sample per cycle while the receiver
// takes each result; the average and level state is updated once per
// sample, as it moves from the input register to the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more sample; after that in_i.ready goes low until the
// result is taken. ready follows out_o.ready combinationally.
// Reset clears the average, the seeded flag and the level, and loads the
// deadband with 16 and the shift with 2; the first sample seeds the average.
`include "assert_macros.svh"

module pot_volume_ema_hysteresis (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pve_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pve_pkg::CfgDataW-1:0]   cfg_data_i,
  pve_stream_if.sink                     in_i,
  pve_stream_if.source                   out_o
);

  logic [pve_pkg::DeadbandW-1:0] deadband_q;
  logic [pve_pkg::ShiftW-1:0]    shift_q;

  logic                          s1_vld_q;
  logic [pve_pkg::SampleW-1:0]   s1_sample_q;
  logic                          out_vld_q;
  pve_pkg::result_t              out_q;

  logic [pve_pkg::SampleW-1:0]   avg_q, avg_d;
  logic                          seeded_q;
  logic [pve_pkg::LevelW-1:0]    level_q, level_d;
  logic                          changed;

  logic adv;
  logic s1_fire;
  logic in_fire;

  assign adv     = !out_vld_q || out_o.ready;
  assign s1_fire = s1_vld_q && adv;
  assign in_i.ready = !s1_vld_q || adv;
  assign in_fire = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= pve_pkg::DeadbandReset;
      shift_q    <= pve_pkg::ShiftReset;
    end else if (cfg_we_i) begin
      unique case (pve_pkg::cfg_reg_e'(cfg_idx_i))
        pve_pkg::RegDeadband: deadband_q <= cfg_data_i[pve_pkg::DeadbandW-1:0];
        pve_pkg::RegShift:    shift_q    <= cfg_data_i[pve_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  pve_avg u_avg (
    .sample_i (s1_sample_q),
    .avg_i    (avg_q),
    .seeded_i (seeded_q),
    .shift_i  (shift_q),
    .avg_o    (avg_d)
  );

  pve_quant u_quant (
    .avg_i      (avg_d),
    .level_i    (level_q),
    .deadband_i (deadband_q),
    .level_o    (level_d),
    .changed_o  (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      avg_q     <= '0;
      seeded_q  <= 1'b0;
      level_q   <= '0;
    end else begin
      if (in_i.ready) s1_vld_q <= in_i.valid;
      if (adv) out_vld_q <= s1_vld_q;
      if (s1_fire) begin
        avg_q    <= avg_d;
        seeded_q <= 1'b1;
        level_q  <= level_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_sample_q <= in_i.data.sample;
    if (s1_fire) begin
      out_q.volume_level   <= level_d;
      out_q.volume_changed <= changed;
      out_q.smoothed_level <= avg_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  `PVE_ASSERT(a_change_moves_level, clk_i, rst_ni,
              (s1_fire && changed) |=> (level_q != $past(level_q)),
              "flagged change left the level as it was")
  `PVE_ASSERT(a_stall_keeps_stage, clk_i, rst_ni,
              (s1_vld_q && out_vld_q && !out_o.ready) |=> s1_vld_q,
              "staged sample lost during a stall")
  `PVE_ASSERT(a_seeded_after_item, clk_i, rst_ni, s1_fire |=> seeded_q,
              "average not marked seeded after a sample")

endmodule

[sv/pve_avg.sv]
module pve_avg (
  input  logic [pve_pkg::SampleW-1:0] sample_i,
  input  logic [pve_pkg::SampleW-1:0] avg_i,
  input  logic                        seeded_i,
  input  logic [pve_pkg::ShiftW-1:0]  shift_i,
  output logic [pve_pkg::SampleW-1:0] avg_o
);

  logic [pve_pkg::SampleW-1:0] base;
  logic signed [pve_pkg::SampleW:0] diff;
  logic signed [pve_pkg::SampleW:0] step;
  logic signed [pve_pkg::SampleW:0] sum;

  // first sample seeds the average, then the normal update runs on it
  assign base = seeded_i ? avg_i : sample_i;
  assign diff = $signed({1'b0, sample_i}) - $signed({1'b0, base});
  // arithmetic shift rounds toward minus infinity
  assign step = diff >>> shift_i;
  assign sum  = $signed({1'b0, base}) + step;
  assign avg_o = sum[pve_pkg::SampleW-1:0];

endmodule

[sv/pve_quant.sv]
module pve_quant (
  input  logic [pve_pkg::SampleW-1:0]   avg_i,
  input  logic [pve_pkg::LevelW-1:0]    level_i,
  input  logic [pve_pkg::DeadbandW-1:0] deadband_i,
  output logic [pve_pkg::LevelW-1:0]    level_o,
  output logic                          changed_o
);

  localparam int ProdW = pve_pkg::SampleW + pve_pkg::LevelW;

  logic [ProdW-1:0]               prod;
  logic [pve_pkg::LevelW-1:0]     q_est;
  logic [pve_pkg::SampleW:0]      rem;
  logic [pve_pkg::LevelW-1:0]     cand;
  logic [pve_pkg::SampleW-1:0]    centre;
  logic signed [pve_pkg::SampleW:0] delta_s;
  logic [pve_pkg::SampleW-1:0]    delta;
  logic                           accept;

  // avg*LevelMax/SampleMax: divide by 2^w first, then correct by at most one
  assign prod  = ProdW'(avg_i) * ProdW'(pve_pkg::LevelMax);
  assign q_est = prod[ProdW-1:pve_pkg::SampleW];
  assign rem   = {1'b0, prod[pve_pkg::SampleW-1:0]} + (pve_pkg::SampleW+1)'(q_est);
  assign cand  = (rem >= (pve_pkg::SampleW+1)'(pve_pkg::SampleMax)) ?
                 q_est + pve_pkg::LevelW'(1) : q_est;

  assign centre  = pve_pkg::CentreTable[level_i];
  assign delta_s = $signed({1'b0, avg_i}) - $signed({1'b0, centre});
  assign delta   = delta_s[pve_pkg::SampleW] ? pve_pkg::SampleW'(-delta_s)
                                             : delta_s[pve_pkg::SampleW-1:0];

  // ends of the scale always pass the deadband
  assign accept = (cand != level_i) &&
                  ((delta >= deadband_i) || (cand == '0) ||
                   (cand == pve_pkg::LevelW'(pve_pkg::LevelMax)));

  assign level_o   = accept ? cand : level_i;
  assign changed_o = accept;

endmodule
